// ===== design/bcm_pkg.sv =====
// Shared types, constants and helpers of the bit-plane context modeler.
package bcm_pkg;

  localparam int COEF_BITS      = 16;
  localparam int MASK_BITS      = COEF_BITS - 1;
  localparam int PLANE_BITS     = 4;
  localparam int MAX_WIDTH      = 1024;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int WIDTH_CFG_BITS = 11;
  localparam int MAX_HEIGHT     = 4096;
  localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
  localparam int HEIGHT_CFG_BITS = 13;
  localparam int CFG_DATA_BITS  = 15;
  localparam int SUM_BITS       = COEF_BITS + 2;

  localparam logic [3:0] VAL_CAP  = 4'd15;
  localparam logic [3:0] SC_N_NEG = 4'd1;
  localparam logic [3:0] SC_N_POS = 4'd2;
  localparam logic [3:0] SC_W_NEG = 4'd3;
  localparam logic [3:0] SC_W_POS = 4'd6;

  typedef enum logic [1:0] {
    REG_BIT_PLANE,
    REG_NEXT_MASK,
    REG_BAND_WIDTH,
    REG_BAND_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic [COEF_BITS-1:0] cur;
    logic [COEF_BITS-1:0] par;
    logic [COEF_BITS-1:0] west;
    logic                 row_first;
    logic                 col_first;
  } stage_t;

  typedef struct packed {
    logic       plane_bit;
    logic [5:0] magnitude_context;
    logic       already_significant;
    logic       sign_coded;
    logic       sign_bit;
    logic [3:0] sign_ctx;
  } result_t;

  function automatic logic [COEF_BITS-1:0] magnitude(input logic [COEF_BITS-1:0] v);
    logic [COEF_BITS-1:0] neg;
    neg = ~v + COEF_BITS'(1);
    return v[COEF_BITS-1] ? neg : v;
  endfunction

endpackage

// ===== design/bcm_if.sv =====
// Coefficient and context channel interfaces.
interface bcm_coef_if import bcm_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [COEF_BITS-1:0] coefficient;
  logic signed [COEF_BITS-1:0] parent_coefficient;

  modport source (output valid, output coefficient, output parent_coefficient, input ready);
  modport sink (input valid, input coefficient, input parent_coefficient, output ready);
endinterface

interface bcm_ctx_if ();
  logic       valid;
  logic       ready;
  logic       plane_bit;
  logic [5:0] magnitude_context;
  logic       already_significant;
  logic       sign_coded;
  logic       sign_bit;
  logic [3:0] sign_ctx;

  modport source (output valid, output plane_bit, output magnitude_context,
                  output already_significant, output sign_coded, output sign_bit,
                  output sign_ctx, input ready);
  modport sink (input valid, input plane_bit, input magnitude_context,
                input already_significant, input sign_coded, input sign_bit,
                input sign_ctx, output ready);
endinterface

// ===== design/bcm_ram.sv =====
// Generic single-clock RAM, one write and one registered read port, read-first.
module bcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AddrBits = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                re,
  input  logic [AddrBits-1:0] raddr,
  output logic [WIDTH-1:0]    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bcm_ctx_calc.sv =====
// Magnitude and sign context arithmetic for one coefficient.
module bcm_ctx_calc import bcm_pkg::*; (
  input  stage_t                stage,
  input  logic [COEF_BITS-1:0]  north_raw,
  input  logic [PLANE_BITS-1:0] bit_plane,
  input  logic [MASK_BITS-1:0]  next_mask,
  output result_t               result
);

  logic [COEF_BITS-1:0] bitmask, nmask, dmask, cur_mag;
  logic [COEF_BITS-1:0] vd, p, n, w, n_mag, w_mag;
  logic [SUM_BITS-1:0]  sum;
  logic [SUM_BITS-3:0]  quarter;
  logic [3:0]           capped, sctx_n, sctx_w;
  logic                 sig, pb;

  always_comb begin
    bitmask = COEF_BITS'(1) << bit_plane;
    nmask   = {1'b0, next_mask};
    dmask   = nmask ^ bitmask;
    cur_mag = magnitude(stage.cur);
    vd      = cur_mag & dmask;
    p       = magnitude(stage.par) & nmask;
    n_mag   = magnitude(north_raw) & nmask;
    w_mag   = magnitude(stage.west) & nmask;
    n       = stage.row_first ? vd : n_mag;
    w       = stage.col_first ? vd : w_mag;

    sctx_n = 4'd0;
    if (!stage.row_first && n_mag != '0) begin
      sctx_n = north_raw[COEF_BITS-1] ? SC_N_NEG : SC_N_POS;
    end
    sctx_w = 4'd0;
    if (!stage.col_first && w_mag != '0) begin
      sctx_w = stage.west[COEF_BITS-1] ? SC_W_NEG : SC_W_POS;
    end

    sum     = {2'b00, vd} + {2'b00, p} + {2'b00, n} + {2'b00, w};
    quarter = sum[SUM_BITS-1:2];
    capped  = (quarter > (SUM_BITS-2)'(VAL_CAP)) ? VAL_CAP : quarter[3:0];

    pb  = (cur_mag & bitmask) != '0;
    sig = vd != '0;

    result.plane_bit           = pb;
    result.magnitude_context   = {w > vd, n > vd, capped};
    result.already_significant = sig;
    result.sign_coded          = pb && !sig;
    result.sign_bit            = stage.cur[COEF_BITS-1];
    result.sign_ctx            = sctx_n + sctx_w;
  end

endmodule

// ===== design/bitplane_context_modeler.sv =====
// Top level of the bit-plane context modeler: registers, line buffer and pipeline.
// Throughput: one coefficient per cycle unless stalled; the line buffer is read and written
// once per beat. A beat is registered in s1, then its result in the result register.
// Reset: synchronous; clears registers to their defaults, counters and pipeline valids.
// The line buffer is not cleared; each entry is written before it is read as north.
module bitplane_context_modeler import bcm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  bcm_coef_if.sink                 coef,
  bcm_ctx_if.source                ctx
);

  logic [PLANE_BITS-1:0]      bit_plane;
  logic [MASK_BITS-1:0]       next_mask;
  logic [WIDTH_CFG_BITS-1:0]  band_width, eff_w;
  logic [HEIGHT_CFG_BITS-1:0] band_height, eff_h;
  logic [COL_BITS-1:0]        column_count;
  logic [ROW_BITS-1:0]        row_count;
  logic [COEF_BITS-1:0]       west_value, north_raw;
  logic                       accept, s1_valid, s1_adv, out_valid;
  stage_t                     s1;
  result_t                    calc, result;

  assign accept     = coef.valid && coef.ready;
  assign s1_adv     = s1_valid && (!out_valid || ctx.ready);
  assign coef.ready = !s1_valid || s1_adv;

  always_comb begin
    eff_w = band_width;
    if (band_width == '0) begin
      eff_w = WIDTH_CFG_BITS'(1);
    end else if (band_width > WIDTH_CFG_BITS'(MAX_WIDTH)) begin
      eff_w = WIDTH_CFG_BITS'(MAX_WIDTH);
    end
    eff_h = band_height;
    if (band_height == '0) begin
      eff_h = HEIGHT_CFG_BITS'(1);
    end else if (band_height > HEIGHT_CFG_BITS'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_CFG_BITS'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_plane   <= '0;
      next_mask   <= '0;
      band_width  <= WIDTH_CFG_BITS'(1);
      band_height <= HEIGHT_CFG_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BIT_PLANE:   bit_plane   <= cfg_data[PLANE_BITS-1:0];
        REG_NEXT_MASK:   next_mask   <= cfg_data[MASK_BITS-1:0];
        REG_BAND_WIDTH:  band_width  <= cfg_data[WIDTH_CFG_BITS-1:0];
        REG_BAND_HEIGHT: band_height <= cfg_data[HEIGHT_CFG_BITS-1:0];
      endcase
    end
  end

  // read-first RAM: a beat reads the old entry and writes its own value in the same cycle
  bcm_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (column_count),
    .wdata (COEF_BITS'(unsigned'(coef.coefficient))),
    .re    (accept),
    .raddr (column_count),
    .rdata (north_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      west_value   <= '0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        west_value <= COEF_BITS'(unsigned'(coef.coefficient));
        if ({1'b0, column_count} + WIDTH_CFG_BITS'(1) >= eff_w) begin
          column_count <= '0;
          if ({1'b0, row_count} + HEIGHT_CFG_BITS'(1) >= eff_h) begin
            row_count <= '0;
          end else begin
            row_count <= row_count + ROW_BITS'(1);
          end
        end else begin
          column_count <= column_count + COL_BITS'(1);
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (ctx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.cur       <= COEF_BITS'(unsigned'(coef.coefficient));
      s1.par       <= COEF_BITS'(unsigned'(coef.parent_coefficient));
      s1.west      <= west_value;
      s1.row_first <= row_count == '0;
      s1.col_first <= column_count == '0;
    end
    if (s1_adv) begin
      result <= calc;
    end
  end

  bcm_ctx_calc u_calc (
    .stage     (s1),
    .north_raw (north_raw),
    .bit_plane (bit_plane),
    .next_mask (next_mask),
    .result    (calc)
  );

  assign ctx.valid               = out_valid;
  assign ctx.plane_bit           = result.plane_bit;
  assign ctx.magnitude_context   = result.magnitude_context;
  assign ctx.already_significant = result.already_significant;
  assign ctx.sign_coded          = result.sign_coded;
  assign ctx.sign_bit            = result.sign_bit;
  assign ctx.sign_ctx            = result.sign_ctx;

`ifndef SYNTH
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !ctx.ready |-> !coef.ready)
    else $error("input taken while both stages are full");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat lost before the context stage");

  a_north_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(north_raw))
    else $error("line buffer data changed under a stalled beat");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ctx.ready |=> out_valid && $stable(result))
    else $error("pending result overwritten");
`endif

endmodule

// ===== bench/bcm_context_check.sv =====
// Context checker: mirrors the modeler's registers, line buffer and counters, predicts each beat.
`timescale 1ns / 100ps
module bcm_context_check import bcm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  cfg_reg_t                 cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  bcm_coef_if                      coef_mon,
  bcm_ctx_if                       ctx_mon,
  output int                       pending,
  output int                       errors
);

  logic [PLANE_BITS-1:0]      plane;
  logic [MASK_BITS-1:0]       coded_mask;
  logic [WIDTH_CFG_BITS-1:0]  width_reg;
  logic [HEIGHT_CFG_BITS-1:0] height_reg;
  logic [COEF_BITS-1:0]       line_buf [MAX_WIDTH];
  logic [COEF_BITS-1:0]       west;
  int unsigned                col;
  int unsigned                row;
  result_t                    ctx_q[$];

  function automatic logic [COEF_BITS-1:0] abs_val(logic [COEF_BITS-1:0] v);
    return v[COEF_BITS-1] ? COEF_BITS'(0 - v) : v;
  endfunction

  function automatic result_t predict_contexts(logic [COEF_BITS-1:0] cur,
                                               logic [COEF_BITS-1:0] par);
    logic [COEF_BITS-1:0] plane_mask, nmask, dmask, vd, pm, nm, wm, north;
    logic [SUM_BITS-1:0]  total;
    logic [5:0]           mctx;
    logic [3:0]           sctx;
    result_t              r;
    plane_mask = COEF_BITS'(1) << plane;
    nmask      = {1'b0, coded_mask};
    dmask      = nmask ^ plane_mask;
    vd         = abs_val(cur) & dmask;
    pm         = abs_val(par) & nmask;
    north      = line_buf[col];
    nm         = vd;
    wm         = vd;
    sctx       = '0;
    // first row / first column: neighbour stands in as VD, no sign read
    if (row != 0) begin
      nm = abs_val(north) & nmask;
      if (nm != 0) sctx += north[COEF_BITS-1] ? SC_N_NEG : SC_N_POS;
    end
    if (col != 0) begin
      wm = abs_val(west) & nmask;
      if (wm != 0) sctx += west[COEF_BITS-1] ? SC_W_NEG : SC_W_POS;
    end
    total = (SUM_BITS'(vd) + pm + nm + wm) >> 2;
    mctx  = (total > VAL_CAP) ? 6'(VAL_CAP) : 6'(total);
    if (nm > vd) mctx += 6'd16;
    if (wm > vd) mctx += 6'd32;
    r.plane_bit           = |(abs_val(cur) & plane_mask);
    r.magnitude_context   = mctx;
    r.already_significant = |vd;
    r.sign_coded          = r.plane_bit & ~r.already_significant;
    r.sign_bit            = cur[COEF_BITS-1];
    r.sign_ctx            = sctx;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t     want;
    int unsigned eff_w, eff_h;
    if (rst) begin
      plane      = '0;
      coded_mask = '0;
      width_reg  = WIDTH_CFG_BITS'(1);
      height_reg = HEIGHT_CFG_BITS'(1);
      west       = '0;
      col        = 0;
      row        = 0;
      errors     = 0;
      ctx_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BIT_PLANE:   plane      = cfg_data[PLANE_BITS-1:0];
          REG_NEXT_MASK:   coded_mask = cfg_data[MASK_BITS-1:0];
          REG_BAND_WIDTH:  width_reg  = cfg_data[WIDTH_CFG_BITS-1:0];
          REG_BAND_HEIGHT: height_reg = cfg_data[HEIGHT_CFG_BITS-1:0];
          default: ;
        endcase
      end
      if (ctx_mon.valid && ctx_mon.ready) begin
        if (ctx_q.size() == 0) begin
          errors++;
          $error("context beat with no coefficient outstanding");
        end else begin
          want = ctx_q.pop_front();
          check_field("plane_bit", 8'(want.plane_bit), 8'(ctx_mon.plane_bit));
          check_field("magnitude_context", 8'(want.magnitude_context),
                      8'(ctx_mon.magnitude_context));
          check_field("already_significant", 8'(want.already_significant),
                      8'(ctx_mon.already_significant));
          check_field("sign_coded", 8'(want.sign_coded), 8'(ctx_mon.sign_coded));
          check_field("sign_bit", 8'(want.sign_bit), 8'(ctx_mon.sign_bit));
          check_field("sign_ctx", 8'(want.sign_ctx), 8'(ctx_mon.sign_ctx));
        end
      end
      if (coef_mon.valid && coef_mon.ready) begin
        ctx_q.push_back(predict_contexts(coef_mon.coefficient, coef_mon.parent_coefficient));
        line_buf[col] = coef_mon.coefficient;
        west          = coef_mon.coefficient;
        eff_w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        eff_h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        // a counter past a shrunk limit wraps on its next advance
        if (col + 1 >= eff_w) begin
          col = 0;
          row = (row + 1 >= eff_h) ? 0 : row + 1;
        end else begin
          col++;
        end
      end
    end
    pending = ctx_q.size();
  end

endmodule

// ===== bench/bitplane_context_modeler_tb.sv =====
// Testbench top: clock, reset, register programming, coefficient stimulus and verdict.
`timescale 1ns / 100ps
module bitplane_context_modeler_tb import bcm_pkg::*; ();

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 440;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  cfg_reg_t                 cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       pending;
  int                       errors;

  bcm_coef_if coef_ch ();
  bcm_ctx_if  ctx_ch ();

  bitplane_context_modeler DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef_ch),
    .ctx       (ctx_ch)
  );

  bcm_context_check u_ctx_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef_mon  (coef_ch),
    .ctx_mon   (ctx_ch),
    .pending   (pending),
    .errors    (errors)
  );

  // band position as the block sees it, to keep width growth at a band start
  logic [WIDTH_CFG_BITS-1:0]  cur_w;
  logic [HEIGHT_CFG_BITS-1:0] cur_h;
  int unsigned                pos_col;
  int unsigned                pos_row;
  int                         hold_req = 0;
  int                         hold_ack = 0;
  int                         hold_left = 0;
  int                         run_left = 0;
  int                         idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned width_limit(int unsigned w);
    return (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
  endfunction

  function automatic int unsigned height_limit(int unsigned h);
    return (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef();
    int unsigned pick, mag;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h8000;
    if (pick <= 3) return COEF_BITS'($urandom);
    mag = $urandom & ((32'd1 << $urandom_range(0, 12)) - 1);
    return $urandom_range(0, 1) ? COEF_BITS'(0 - mag) : COEF_BITS'(mag);
  endfunction

  task automatic send_beat(logic [COEF_BITS-1:0] c, logic [COEF_BITS-1:0] p);
    coef_ch.valid              <= 1'b1;
    coef_ch.coefficient        <= c;
    coef_ch.parent_coefficient <= p;
    do @(posedge clk); while (!coef_ch.ready);
    if (pos_col + 1 >= width_limit(cur_w)) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= height_limit(cur_h)) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  task automatic pause_random();
    int unsigned pick, n;
    pick = $urandom_range(0, 99);
    n = (pick < 60) ? 0 : ((pick < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30));
    if (n != 0) begin
      coef_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    coef_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(v);
    if (idx == REG_BAND_WIDTH) cur_w = WIDTH_CFG_BITS'(v);
    if (idx == REG_BAND_HEIGHT) cur_h = HEIGHT_CFG_BITS'(v);
    @(posedge clk);
  endtask

  // a wider band only starts at row 0, column 0, so no north read hits an unwritten entry
  task automatic reconfigure(int unsigned plane_v, int unsigned mask_v, int unsigned w,
                             int unsigned h);
    wait_drained();
    if (width_limit(w) > width_limit(cur_w) && (pos_col != 0 || pos_row != 0)) begin
      write_reg(REG_BAND_HEIGHT, 1);
      cfg_we <= 1'b0;
      while (pos_col != 0 || pos_row != 0) begin
        send_beat(rand_coef(), rand_coef());
        pause_random();
      end
      wait_drained();
    end
    write_reg(REG_BIT_PLANE, plane_v);
    write_reg(REG_NEXT_MASK, mask_v);
    write_reg(REG_BAND_WIDTH, w);
    write_reg(REG_BAND_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    int unsigned pick;
    if (rst) begin
      ctx_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      ctx_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      ctx_ch.ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        ctx_ch.ready <= 1'b1;
        run_left     <= $urandom_range(0, 15);
      end else if (pick < 90) begin
        ctx_ch.ready <= 1'b0;
        run_left     <= $urandom_range(0, 2);
      end else begin
        ctx_ch.ready <= 1'b0;
        run_left     <= $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (coef_ch.valid && coef_ch.ready) || (ctx_ch.valid && ctx_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned plane_v, mask_v, w, h, n_items, random_sent;
    bit          burst;
    rst                        <= 1'b1;
    cfg_we                     <= 1'b0;
    cfg_index                  <= REG_BIT_PLANE;
    cfg_data                   <= '0;
    coef_ch.valid              <= 1'b0;
    coef_ch.coefficient        <= '0;
    coef_ch.parent_coefficient <= '0;
    cur_w   = WIDTH_CFG_BITS'(1);
    cur_h   = HEIGHT_CFG_BITS'(1);
    pos_col = 0;
    pos_row = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: every beat is a first pixel, no west sign read
    send_beat(16'h7FFF, 16'h8001);
    send_beat(16'h8000, 16'h7FFF);

    // plane fifteen, full mask, field extremes
    reconfigure(15, 15'h7FFF, 3, 3);
    send_beat(16'h8000, 16'h0001);
    send_beat(16'h7FFF, 16'h8000);
    send_beat(16'h8001, 16'hFFFF);
    send_beat(16'h0000, 16'h7FFF);
    send_beat(16'h0001, 16'h8001);
    send_beat(16'hFFFF, 16'h0000);
    send_beat(16'h5555, 16'hAAAA);
    send_beat(16'hAAAA, 16'h5555);
    send_beat(16'h4000, 16'hC000);

    // zero width and height act as one
    reconfigure(0, 0, 0, 0);
    send_beat(16'h0001, 16'hFFFF);
    send_beat(16'hFFFF, 16'h0001);

    // neighbours larger than VD, capped sum, signs of north and west
    reconfigure(2, 15'h7FFC, 4, 2);
    send_beat(16'h0004, 16'h0000);
    send_beat(16'h0040, 16'h0000);
    send_beat(16'h0008, 16'h7000);
    send_beat(16'hFFF8, 16'h0004);
    send_beat(16'h0000, 16'h0010);
    send_beat(16'h7FF0, 16'h7FF0);
    send_beat(16'hFFFC, 16'h0000);
    send_beat(16'h0000, 16'h0000);

    // long hold-off on the result side while beats keep coming
    reconfigure(4, 15'h7FF0, 7, 5);
    hold_req <= hold_req + 1;
    repeat (40) send_beat(rand_coef(), rand_coef());
    wait_drained();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      plane_v = $urandom_range(0, 15);
      mask_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                            : ((32'h7FFF << plane_v) & 32'h7FFF);
      if ($urandom_range(0, 7) != 0) begin
        w = $urandom_range(1, 12);
      end else begin
        case ($urandom_range(0, 3))
          0:       w = 0;
          1:       w = MAX_WIDTH;
          2:       w = 1500;
          default: w = 2047;
        endcase
      end
      if ($urandom_range(0, 4) != 0) begin
        h = $urandom_range(1, 6);
      end else begin
        case ($urandom_range(0, 3))
          0:       h = 0;
          1:       h = MAX_HEIGHT;
          2:       h = MAX_HEIGHT + 1;
          default: h = 8191;
        endcase
      end
      reconfigure(plane_v, mask_v, w, h);
      n_items = $urandom_range(8, 50);
      burst   = ($urandom_range(0, 3) == 0);
      repeat (n_items) begin
        send_beat(rand_coef(), rand_coef());
        if (!burst) pause_random();
      end
      random_sent += n_items;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
